// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/rsce_pkg.sv
// Package for the self-clutter estimator: sizes, op codes, command type.
// No dependencies.
package rsce_pkg;
  localparam int MaxRanges = 256;
  localparam int MaxPulses = 16;
  localparam int MaxLags = 32;
  localparam int PowerBits = 32;
  localparam int GateW = $clog2(MaxRanges);
  localparam int PulseW = $clog2(MaxPulses);
  localparam int LagW = $clog2(MaxLags);
  localparam int SumW = 39;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OpLoadPower = 2'd0,
    OpLoadPulse = 2'd1,
    OpLoadLag = 2'd2,
    OpEstimate = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegNumRanges = 3'd0,
    RegFirstRange = 3'd1,
    RegSpl = 3'd2,
    RegNumPulses = 3'd3,
    RegNumLags = 3'd4
  } reg_e;

  typedef struct packed {
    logic [7:0] gate;
    logic [8:0] nr;
    logic [6:0] spl;
    logic [5:0] np;
    logic [6:0] nl;
  } cmd_t;

  // 32x32 product root takes 32 digit steps
  localparam int RootSteps = 32;
endpackage

// File: rtl/core/radar_self_clutter_estimator.sv
// A load takes effect at its accepting edge; an estimate walks its lags in turn, and each lag
// steps through 2*np + np*np root terms, computing the valid ones and skipping the rest.
// Each lag result is registered in SEmit after its sum closes, one-cycle strobe; receiver cannot stall.
// Two estimates queue behind the running one; a load waits until no estimate is pending.
// Reset clears control and loads the registers with their defaults; stores are undefined until written.
// Depends on rsce_pkg, rsce_front, rsce_back.
module radar_self_clutter_estimator
  import rsce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  slot_i,
  input  logic [31:0] power_value_i,
  input  logic [7:0]  pulse_position_i,
  input  logic [7:0]  lag_first_i,
  input  logic [7:0]  lag_second_i,
  input  logic [7:0]  target_gate_i,
  output logic        valid_o,
  output logic [4:0]  lag_index_o,
  output logic [38:0] clutter_power_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [8:0] nr_q; logic [9:0] frs_q; logic [6:0] spl_q;
  logic [4:0] np_q; logic [5:0] nl_q;
  logic wr;
  logic pw_we, pt_we, lt_we, cmd_valid, cmd_pop, f_busy, b_idle;
  logic [GateW-1:0] pw_addr; logic [PowerBits-1:0] pw_data;
  logic [PulseW-1:0] pt_addr; logic [7:0] pt_data;
  logic [LagW-1:0] lt_addr; logic [15:0] lt_data;
  cmd_t cmd;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q <= 9'd75; frs_q <= 10'd4; spl_q <= 7'd8; np_q <= 5'd8; nl_q <= 6'd23;
    end else if (wr && paddr[1:0] == 2'd0) begin
      unique case (paddr[4:2])
        RegNumRanges: nr_q <= pwdata[8:0];
        RegFirstRange: frs_q <= pwdata[9:0];
        RegSpl: spl_q <= pwdata[6:0];
        RegNumPulses: np_q <= pwdata[4:0];
        RegNumLags: nl_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[4:2])
      RegNumRanges: prdata = 32'(nr_q);
      RegFirstRange: prdata = 32'(frs_q);
      RegSpl: prdata = 32'(spl_q);
      RegNumPulses: prdata = 32'(np_q);
      RegNumLags: prdata = 32'(nl_q);
      default: prdata = '0;
    endcase
  end

  assign busy = f_busy;

  rsce_front u_front (
    .clk_i, .rst_ni, .start_i(start), .operation_i, .slot_i, .power_value_i,
    .pulse_position_i, .lag_first_i, .lag_second_i, .target_gate_i,
    .num_ranges_i(nr_q), .spl_i(spl_q), .num_pulses_i(np_q), .num_lags_i(nl_q),
    .back_idle_i(b_idle),
    .busy_o(f_busy), .pw_we_o(pw_we), .pw_addr_o(pw_addr), .pw_data_o(pw_data),
    .pt_we_o(pt_we), .pt_addr_o(pt_addr), .pt_data_o(pt_data),
    .lt_we_o(lt_we), .lt_addr_o(lt_addr), .lt_data_o(lt_data),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  rsce_back u_back (
    .clk_i, .rst_ni, .pw_we_i(pw_we), .pw_addr_i(pw_addr), .pw_data_i(pw_data),
    .pt_we_i(pt_we), .pt_addr_i(pt_addr), .pt_data_i(pt_data),
    .lt_we_i(lt_we), .lt_addr_i(lt_addr), .lt_data_i(lt_data),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop), .idle_o(b_idle),
    .valid_o, .lag_index_o, .clutter_power_o, .last_o
  );
endmodule

// File: rtl/core/rsce_isqrt.sv
// Iterative floored square root of a 64-bit value, one result bit per cycle.
// Depends on rsce_pkg.
module rsce_isqrt
  import rsce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [63:0] val_q, val_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [65:0] trial;
  logic [65:0] rem_sh;

  always_comb begin
    rem_sh = {rem_q, val_q[63:62]};
    trial  = {32'd0, root_q, 2'b01};
    rem_d = rem_q; root_d = root_q; val_d = val_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = '0; root_d = '0; val_d = value_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d = 64'(rem_sh - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[63:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(RootSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d; val_q <= val_d;
  end
  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// File: rtl/core/rsce_front.sv
// Front end: takes items, writes the tables, queues estimate commands.
// Depends on rsce_pkg.
module rsce_front
  import rsce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  slot_i,
  input  logic [31:0] power_value_i,
  input  logic [7:0]  pulse_position_i,
  input  logic [7:0]  lag_first_i,
  input  logic [7:0]  lag_second_i,
  input  logic [7:0]  target_gate_i,
  input  logic [8:0]  num_ranges_i,
  input  logic [6:0]  spl_i,
  input  logic [4:0]  num_pulses_i,
  input  logic [5:0]  num_lags_i,
  input  logic        back_idle_i,
  output logic        busy_o,
  output logic        pw_we_o,
  output logic [GateW-1:0] pw_addr_o,
  output logic [PowerBits-1:0] pw_data_o,
  output logic        pt_we_o,
  output logic [PulseW-1:0] pt_addr_o,
  output logic [7:0]  pt_data_o,
  output logic        lt_we_o,
  output logic [LagW-1:0] lt_addr_o,
  output logic [15:0] lt_data_o,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);
  cmd_t        q_mem [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        acc, push;
  logic [8:0]  nr;
  logic [5:0]  np;
  logic [6:0]  nl;

  // hold every item while the queue is full, and hold loads while any estimate is queued or in progress
  assign busy_o = (cnt_q == 2'(QDepth))
                  || ((op_e'(operation_i) != OpEstimate) && !back_idle_i);
  assign acc = start_i && !busy_o;
  assign nr = (num_ranges_i > 9'(MaxRanges)) ? 9'(MaxRanges) : num_ranges_i;
  assign np = (num_pulses_i > 5'(MaxPulses)) ? 6'(MaxPulses) : {1'b0, num_pulses_i};
  assign nl = (num_lags_i > 6'(MaxLags)) ? 7'(MaxLags) : {1'b0, num_lags_i};
  assign push = acc && (op_e'(operation_i) == OpEstimate) && (nl != 7'd0)
                && ({1'b0, target_gate_i} < nr);

  assign pw_we_o = acc && (op_e'(operation_i) == OpLoadPower);
  assign pw_addr_o = slot_i[GateW-1:0];
  assign pw_data_o = power_value_i[PowerBits-1:0];
  assign pt_we_o = acc && (op_e'(operation_i) == OpLoadPulse) && (slot_i < 8'(MaxPulses));
  assign pt_addr_o = slot_i[PulseW-1:0];
  assign pt_data_o = pulse_position_i;
  assign lt_we_o = acc && (op_e'(operation_i) == OpLoadLag) && (slot_i < 8'(MaxLags));
  assign lt_addr_o = slot_i[LagW-1:0];
  assign lt_data_o = {lag_second_i, lag_first_i};

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_mem[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= '{gate: target_gate_i, nr: nr, spl: spl_i, np: np, nl: nl};
  end
endmodule

// File: rtl/core/rsce_back.sv
// Back end: walks lags, pulses and pulse pairs, sums product roots.
// Depends on rsce_pkg and rsce_isqrt.
module rsce_back
  import rsce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pw_we_i,
  input  logic [GateW-1:0] pw_addr_i,
  input  logic [PowerBits-1:0] pw_data_i,
  input  logic        pt_we_i,
  input  logic [PulseW-1:0] pt_addr_i,
  input  logic [7:0]  pt_data_i,
  input  logic        lt_we_i,
  input  logic [LagW-1:0] lt_addr_i,
  input  logic [15:0] lt_data_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        idle_o,
  output logic        valid_o,
  output logic [4:0]  lag_index_o,
  output logic [SumW-1:0] clutter_power_o,
  output logic        last_o
);
  typedef enum logic [3:0] {
    SIdle, STgt, SLag, SMapA, SMapB, SRdA, SRdB, SMul, SRoot, SWait, SNext, SEmit
  } state_e;
  typedef enum logic [1:0] { TermT2, TermT1, TermX } term_e;

  logic [PowerBits-1:0] pw_mem [MaxRanges];
  logic [7:0]  pt_mem [MaxPulses];
  logic [15:0] lt_mem [MaxLags];
  logic [PowerBits-1:0] pw_rd_q;
  logic [GateW-1:0] pw_ra;

  state_e st_q;
  term_e  term_q;
  cmd_t   cmd_q;
  logic [6:0]  lag_q;
  logic [5:0]  p_q, q_q;
  logic [15:0] lp_q;
  logic [7:0]  pos_q;
  logic [31:0] tgt_q, pa_q;
  logic        ga_ok_q, gb_ok_q;
  logic [GateW-1:0] ga_q, gb_q;
  logic [40:0] sum_q;
  logic        sq_start;
  logic [63:0] prod_q;
  logic        sq_done;
  logic [31:0] sq_root;
  logic signed [17:0] diff;
  logic signed [26:0] gcalc;
  logic        g_ok;
  logic        valid_q, last_q;
  logic [4:0]  lidx_q;
  logic [SumW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (pw_we_i) pw_mem[pw_addr_i] <= pw_data_i;
    pw_rd_q <= pw_mem[pw_ra];
  end
  always_ff @(posedge clk_i) begin
    if (pt_we_i) pt_mem[pt_addr_i] <= pt_data_i;
    if (lt_we_i) lt_mem[lt_addr_i] <= lt_data_i;
  end

  rsce_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .value_i(prod_q),
    .done_o(sq_done), .root_o(sq_root)
  );

  // map lag time through pos_q; SMapA uses first time, SMapB second
  always_comb begin
    diff = (st_q == SMapA) ? 18'(signed'({1'b0, lp_q[7:0]})) - 18'(signed'({1'b0, pos_q}))
                           : 18'(signed'({1'b0, lp_q[15:8]})) - 18'(signed'({1'b0, pos_q}));
    gcalc = 27'(diff * signed'({1'b0, cmd_q.spl})) + 27'(signed'({1'b0, cmd_q.gate}));
    g_ok = (gcalc != 27'(signed'({1'b0, cmd_q.gate}))) && (gcalc >= 0)
           && (gcalc < 27'(signed'({1'b0, cmd_q.nr})));
  end

  always_comb begin
    pw_ra = cmd_q.gate[GateW-1:0];
    unique case (st_q)
      SRdA: pw_ra = ga_q;
      SRdB: pw_ra = gb_q;
      default: pw_ra = cmd_q.gate[GateW-1:0];
    endcase
  end

  assign cmd_pop_o = (st_q == SIdle) && cmd_valid_i;
  assign idle_o = (st_q == SIdle) && !cmd_valid_i;
  assign sq_start = (st_q == SRoot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; valid_q <= 1'b0; term_q <= TermT2;
      lag_q <= '0; p_q <= '0; q_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (st_q)
        SIdle: if (cmd_valid_i) begin
          cmd_q <= cmd_i; lag_q <= '0; st_q <= STgt;
        end
        STgt: st_q <= SLag;
        SLag: begin
          tgt_q <= (lag_q == 7'd0) ? pw_rd_q : tgt_q;
          lp_q <= lt_mem[lag_q[LagW-1:0]];
          sum_q <= '0; term_q <= TermT2; p_q <= '0; q_q <= '0;
          pos_q <= pt_mem[PulseW'(0)];
          st_q <= SMapA;
        end
        SMapA: begin
          ga_ok_q <= g_ok; ga_q <= gcalc[GateW-1:0];
          pos_q <= pt_mem[(term_q == TermX) ? q_q[PulseW-1:0] : p_q[PulseW-1:0]];
          st_q <= SMapB;
        end
        SMapB: begin
          gb_ok_q <= g_ok; gb_q <= gcalc[GateW-1:0];
          st_q <= SRdA;
        end
        SRdA: st_q <= SRdB;
        SRdB: begin
          pa_q <= pw_rd_q;
          unique case (term_q)
            TermT2: if (gb_ok_q) st_q <= SMul; else st_q <= SNext;
            TermT1: if (ga_ok_q) st_q <= SMul; else st_q <= SNext;
            default: if (ga_ok_q && gb_ok_q) st_q <= SMul; else st_q <= SNext;
          endcase
        end
        SMul: st_q <= SRoot;
        SRoot: st_q <= SWait;
        SWait: if (sq_done) begin
          sum_q <= sum_q + 41'(sq_root); st_q <= SNext;
        end
        SNext: begin
          priority if (term_q == TermT2) begin
            term_q <= TermT1;
            pos_q <= pt_mem[p_q[PulseW-1:0]];
            st_q <= SMapA;
          end else if (term_q == TermT1 && p_q + 6'd1 < cmd_q.np) begin
            term_q <= TermT2; p_q <= p_q + 6'd1;
            pos_q <= pt_mem[PulseW'(p_q + 6'd1)];
            st_q <= SMapA;
          end else if (term_q == TermT1) begin
            term_q <= TermX; p_q <= '0; q_q <= '0;
            pos_q <= pt_mem[PulseW'(0)];
            st_q <= SMapA;
          end else if (q_q + 6'd1 < cmd_q.np) begin
            q_q <= q_q + 6'd1;
            pos_q <= pt_mem[p_q[PulseW-1:0]];
            st_q <= SMapA;
          end else if (p_q + 6'd1 < cmd_q.np) begin
            p_q <= p_q + 6'd1; q_q <= '0;
            pos_q <= pt_mem[PulseW'(p_q + 6'd1)];
            st_q <= SMapA;
          end else begin
            st_q <= SEmit;
          end
        end
        SEmit: begin
          valid_q <= 1'b1;
          lidx_q <= lag_q[4:0];
          out_q <= (sum_q > 41'((64'd1 << SumW) - 1)) ? '1 : sum_q[SumW-1:0];
          last_q <= (lag_q + 7'd1 == cmd_q.nl);
          lag_q <= lag_q + 7'd1;
          st_q <= (lag_q + 7'd1 == cmd_q.nl) ? SIdle : SLag;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // product operands: T*Pb, T*Pa, Pa*Pb
  always_ff @(posedge clk_i) begin
    if (st_q == SMul) begin
      unique case (term_q)
        TermT2: prod_q <= 64'(tgt_q) * 64'(pw_rd_q);
        TermT1: prod_q <= 64'(tgt_q) * 64'(pa_q);
        default: prod_q <= 64'(pa_q) * 64'(pw_rd_q);
      endcase
    end
  end

  assign valid_o = valid_q;
  assign lag_index_o = lidx_q;
  assign clutter_power_o = out_q;
  assign last_o = last_q;
endmodule

// File: rtl/core/rsce_checker.sv
// Port-level checker for the estimator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rsce_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input logic last_o,
  input logic [4:0] lag_index_o,
  input logic pready
);
  `ASSERT_IMPL(a_pready, clk_i, rst_ni, 1'b1, pready)
  `ASSERT_NEXT(a_one_strobe, clk_i, rst_ni, valid_o, !valid_o)
  `ASSERT_IMPL(a_busy_known, clk_i, rst_ni, start, !$isunknown(busy))
  `ASSERT_IMPL(a_result_known, clk_i, rst_ni, valid_o, !$isunknown({lag_index_o, last_o}))
endmodule

bind radar_self_clutter_estimator rsce_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .valid_o, .last_o, .lag_index_o, .pready
);

// File: tb/tb_radar_self_clutter_estimator.sv
// Self-checking testbench for radar_self_clutter_estimator: loads the power, pulse and lag stores,
// runs estimates under several register settings and checks every lag result against a predictor.
// Depends on rsce_pkg and the block itself.
`timescale 1ns / 1ps

module tb_radar_self_clutter_estimator;
  import rsce_pkg::*;

  typedef struct {
    op_e         op;
    logic [7:0]  slot;
    logic [31:0] power;
    logic [7:0]  pos;
    logic [7:0]  lag_a;
    logic [7:0]  lag_b;
    logic [7:0]  gate;
  } item_t;

  typedef struct {
    logic [4:0]  lag;
    logic [38:0] clutter;
    logic        last;
  } lag_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [7:0]  slot_i = '0;
  logic [31:0] power_value_i = '0;
  logic [7:0]  pulse_position_i = '0;
  logic [7:0]  lag_first_i = '0;
  logic [7:0]  lag_second_i = '0;
  logic [7:0]  target_gate_i = '0;
  logic        valid_o;
  logic [4:0]  lag_index_o;
  logic [38:0] clutter_power_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  radar_self_clutter_estimator uut (.*);

  always #5 clk_i = ~clk_i;

  item_t       pending_items[$];
  lag_result_t expected_lags[$];
  int          errors = 0;
  logic        took = 1'b0;

  int unsigned cfg_nr = 75, cfg_frs = 4, cfg_spl = 8, cfg_np = 8, cfg_nl = 23;
  logic [31:0] gate_power[MaxRanges];
  logic [7:0]  pulse_time[MaxPulses];
  logic [7:0]  lag_time_a[MaxLags];
  logic [7:0]  lag_time_b[MaxLags];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic int gate_of(int t, int p, int g, int nr);
    longint x;
    x = longint'(cfg_spl) * (longint'(t) - longint'(p)) + longint'(g);
    if (x == g || x < 0 || x >= nr) return -1;
    return int'(x);
  endfunction

  function automatic void predict_clutter(int g);
    int nr, np, nl;
    int ga[MaxPulses], gb[MaxPulses];
    longint unsigned acc, tgt;
    lag_result_t r;
    nr = (cfg_nr > MaxRanges) ? MaxRanges : cfg_nr;
    np = (cfg_np > MaxPulses) ? MaxPulses : cfg_np;
    nl = (cfg_nl > MaxLags) ? MaxLags : cfg_nl;
    if (g >= nr || nl == 0) return;
    tgt = gate_power[g];
    for (int l = 0; l < nl; l++) begin
      acc = 0;
      for (int p = 0; p < np; p++) begin
        ga[p] = gate_of(lag_time_a[l], pulse_time[p], g, nr);
        gb[p] = gate_of(lag_time_b[l], pulse_time[p], g, nr);
      end
      for (int p = 0; p < np; p++) begin
        if (gb[p] >= 0) acc += root64(tgt * gate_power[gb[p]]);
        if (ga[p] >= 0) acc += root64(tgt * gate_power[ga[p]]);
      end
      for (int p = 0; p < np; p++) begin
        if (ga[p] < 0) continue;
        for (int q = 0; q < np; q++)
          if (gb[q] >= 0)
            acc += root64(64'(gate_power[ga[p]]) * 64'(gate_power[gb[q]]));
      end
      if (acc > 64'h7F_FFFF_FFFF) acc = 64'h7F_FFFF_FFFF;
      r.lag = l[4:0];
      r.clutter = acc[38:0];
      r.last = (l + 1 == nl);
      expected_lags.push_back(r);
    end
  endfunction

  function automatic void apply_item(item_t it);
    case (it.op)
      OpLoadPower: gate_power[it.slot] = it.power;
      OpLoadPulse: if (it.slot < MaxPulses) pulse_time[it.slot] = it.pos;
      OpLoadLag: if (it.slot < MaxLags) begin
        lag_time_a[it.slot] = it.lag_a;
        lag_time_b[it.slot] = it.lag_b;
      end
      default: predict_clutter(it.gate);
    endcase
  endfunction

  // accept items and check results
  always @(posedge clk_i) begin
    item_t it;
    lag_result_t e;
    took <= start && !busy && rst_ni;
    if (rst_ni && valid_o) begin
      if (expected_lags.size() == 0) begin
        $display("%0t: result with none expected: lag %0d clutter %0d last %0b", $realtime,
                 lag_index_o, clutter_power_o, last_o);
        errors++;
      end else begin
        e = expected_lags.pop_front();
        if (lag_index_o !== e.lag) begin
          $display("%0t: lag_index expected %0d actual %0d", $realtime, e.lag, lag_index_o);
          errors++;
        end
        if (clutter_power_o !== e.clutter) begin
          $display("%0t: clutter_power expected %0d actual %0d", $realtime, e.clutter,
                   clutter_power_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, e.last, last_o);
          errors++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      it.op = op_e'(operation_i);
      it.slot = slot_i;
      it.power = power_value_i;
      it.pos = pulse_position_i;
      it.lag_a = lag_first_i;
      it.lag_b = lag_second_i;
      it.gate = target_gate_i;
      apply_item(it);
    end
  end

  int burst_left = 0, gap_left = 0;

  // driver: bursts of items with random gaps
  always @(negedge clk_i) begin
    logic nxt;
    item_t it;
    nxt = start;
    if (rst_ni && (!start || took)) begin
      nxt = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        operation_i <= it.op;
        slot_i <= it.slot;
        power_value_i <= it.power;
        pulse_position_i <= it.pos;
        lag_first_i <= it.lag_a;
        lag_second_i <= it.lag_b;
        target_gate_i <= it.gate;
        nxt = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
    start <= nxt;
  end

  task automatic reg_write(reg_e idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(int'(idx) * 4);
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegNumRanges: cfg_nr = val & 9'h1FF;
      RegFirstRange: cfg_frs = val & 10'h3FF;
      RegSpl: cfg_spl = val & 7'h7F;
      RegNumPulses: cfg_np = val & 5'h1F;
      default: cfg_nl = val & 6'h3F;
    endcase
  endtask

  task automatic set_regs(int unsigned nr, int unsigned frs, int unsigned spl,
                          int unsigned np, int unsigned nl);
    reg_write(RegNumRanges, nr);
    reg_write(RegFirstRange, frs);
    reg_write(RegSpl, spl);
    reg_write(RegNumPulses, np);
    reg_write(RegNumLags, nl);
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !start);
    wait (expected_lags.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic item_t mk(op_e op, int slot, logic [31:0] pw, int pos, int la, int lb,
                               int g);
    item_t it;
    it.op = op;
    it.slot = slot[7:0];
    it.power = pw;
    it.pos = pos[7:0];
    it.lag_a = la[7:0];
    it.lag_b = lb[7:0];
    it.gate = g[7:0];
    return it;
  endfunction

  function automatic logic [31:0] rand_power();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic int near_time();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 255);
  endfunction

  function automatic item_t rand_item();
    int nr, k;
    nr = (cfg_nr > MaxRanges) ? MaxRanges : cfg_nr;
    k = $urandom_range(0, 99);
    if (k < 30)
      return mk(OpLoadPower, $urandom_range(0, 255), rand_power(), $urandom, $urandom,
                $urandom, $urandom);
    if (k < 45)
      return mk(OpLoadPulse, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                : $urandom_range(0, 15), $urandom, near_time(), $urandom, $urandom, $urandom);
    if (k < 60)
      return mk(OpLoadLag, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                : $urandom_range(0, 31), $urandom, $urandom, near_time(), near_time(),
                $urandom);
    return mk(OpEstimate, $urandom, $urandom, $urandom, $urandom, $urandom,
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
              : $urandom_range(0, nr - 1));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill the lower gates and both tables so no estimate reads an unwritten entry
    for (int i = 0; i < MaxRanges / 2; i++)
      pending_items.push_back(mk(OpLoadPower, i, rand_power(), 0, 0, 0, 0));
    for (int i = 0; i < MaxPulses; i++)
      pending_items.push_back(mk(OpLoadPulse, i, 0, near_time(), 0, 0, 0));
    for (int i = 0; i < MaxLags; i++)
      pending_items.push_back(mk(OpLoadLag, i, 0, 0, near_time(), near_time(), 0));
    drain();

    set_regs(75, 0, 2, 3, 4);
    pending_items.push_back(mk(OpLoadPower, 0, 32'd0, 0, 0, 0, 0));
    pending_items.push_back(mk(OpLoadPower, 255, 32'hFFFF_FFFF, 255, 255, 255, 255));
    pending_items.push_back(mk(OpLoadPower, 7, 32'hAAAA_5555, 0, 0, 0, 0));
    pending_items.push_back(mk(OpLoadPulse, 200, 0, 8'hAA, 0, 0, 0));
    pending_items.push_back(mk(OpLoadPulse, 15, 0, 255, 0, 0, 0));
    pending_items.push_back(mk(OpLoadLag, 255, 0, 0, 8'h55, 8'hAA, 0));
    pending_items.push_back(mk(OpLoadLag, 31, 0, 0, 255, 0, 0));
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 74));
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 75));
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 255));
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 7));
    drain();

    // saturation: every term at full power, pulses clamped to the table depth
    set_regs(256, 1023, 1, 31, 2);
    pending_items.push_back(mk(OpLoadPower, 100, 32'hFFFF_FFFF, 0, 0, 0, 0));
    for (int i = 105; i < 122; i++)
      pending_items.push_back(mk(OpLoadPower, i, 32'hFFFF_FFFF, 0, 0, 0, 0));
    for (int i = 0; i < MaxPulses; i++)
      pending_items.push_back(mk(OpLoadPulse, i, 0, i, 0, 0, 0));
    pending_items.push_back(mk(OpLoadLag, 0, 0, 0, 20, 21, 0));
    pending_items.push_back(mk(OpLoadLag, 1, 0, 0, 21, 20, 0));
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 100));
    drain();

    set_regs(256, 0, 1, 16, 1);
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 90));
    drain();

    set_regs(511, 5, 0, 2, 3);
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 255));
    pending_items.push_back(mk(OpEstimate, 0, 0, 0, 0, 0, 100));
    drain();

    set_regs(40, 9, 3, 2, 0);
    random_phase(10);
    set_regs(1, 100, 64, 1, 63);
    random_phase(10);
    set_regs(30, 1, 1, 1, 32);
    random_phase(10);
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(16, 96),
               $urandom_range(0, 1023),
               ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4),
               $urandom_range(1, 3), $urandom_range(1, 8));
      random_phase(15);
    end

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rsce_pkg.sv
rtl/core/rsce_isqrt.sv
rtl/core/rsce_front.sv
rtl/core/rsce_back.sv
rtl/core/radar_self_clutter_estimator.sv
rtl/core/rsce_checker.sv
tb/tb_radar_self_clutter_estimator.sv
